### hw/rtl/text_console_cursor_scroll_top_assert.svh
// Assertion macros for the text console RTL.
// Included by the modules that check their own control logic.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH

// check a property on every clock edge outside reset
`define TCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition implies a consequence in the next cycle
`define TCC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tcc_pkg.sv
// Shared types and constants for the text console.
// No dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
   localparam logic [7:0] RETURN_CHAR  = 8'h0d;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] ATTR_RESET   = 8'h0f;

   typedef struct packed {
      logic       put_en;
      logic       clear_en;
      logic [7:0] char_code;
   } tcc_step_type;

   typedef struct packed {
      logic write_en;
      logic scroll;
   } tcc_move_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FILL   = 4'b0010,
      ST_COPY   = 4'b0100,
      ST_FINISH = 4'b1000
   } tcc_state_type;

endpackage

### hw/rtl/text_console_cursor_scroll_top.sv
// Text console: screen memory, cursor, scroll and clear sequencer.
// Put, read, carriage return and no-op go straight to the finish state, which loads the
// result register once the output is free. A put that scrolls first runs the row copy, then
// bottom row blanking; clear first blanks every cell. A new request is taken only in idle, so
// a held result stalls the input. The single-write-port screen RAM sets the long cases.
// Reset homes the cursor and sets the attribute to 0x0f; screen contents stay
// undefined until the first clear, with no clearing pass.
`timescale 1ns / 1ps

module text_console_cursor_scroll_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // config write: text_attribute [7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
   input  logic [23:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_word [15:0], cursor_col [22:16], cursor_row [27:23], zero [31:28]
   output logic [31:0] rsp_tdata
);
   import tcc_pkg::*;
   `include "text_console_cursor_scroll_top_assert.svh"

   localparam int COL_W    = $clog2(COLUMNS);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int COPY_LEN = CELLS - COLUMNS;

   logic [15:0]       screen_ff [0:CELLS-1];
   logic [15:0]       rd_data_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;

   tcc_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic              pend_ff, pend_in;
   logic              is_read_ff, is_read_in;
   logic [7:0]        attr_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_cell_ff;
   logic [6:0]        rsp_col_ff;
   logic [4:0]        rsp_row_ff;
   logic              rsp_load;

   logic [7:0]        req_char;
   logic [4:0]        req_row;
   logic [6:0]        req_col;
   logic              req_accept, read_ok, copy_issue;
   logic [ADDR_W:0]   read_addr_full;
   logic [ADDR_W-1:0] cursor_addr;
   logic [15:0]       blank_word;

   tcc_step_type      step;
   tcc_move_type      move;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;

   assign req_char   = req_tdata[7:0];
   assign req_row    = req_tdata[12:8];
   assign req_col    = req_tdata[19:13];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign blank_word = {attr_ff, SPACE_CHAR};

   assign step.put_en    = req_accept && (req_tuser == CMD_PUT);
   assign step.clear_en  = req_accept && (req_tuser == CMD_CLEAR);
   assign step.char_code = req_char;

   tcc_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .move       (move),
      .cursor_col (cur_col),
      .cursor_row (cur_row)
   );

   assign read_ok = (int'(req_row) < ROWS) && (int'(req_col) < COLUMNS);
   assign read_addr_full = (ADDR_W+1)'(req_row) * (ADDR_W+1)'(COLUMNS)
                         + (ADDR_W+1)'(req_col);
   assign cursor_addr = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(COLUMNS)) + ADDR_W'(cur_col);
   assign copy_issue  = (ptr_ff < ADDR_W'(COPY_LEN));
   assign rsp_load    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      waddr_in   = waddr_ff;
      pend_in    = 1'b0;
      is_read_in = is_read_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = ptr_ff;
      mem_raddr  = ptr_ff + ADDR_W'(COLUMNS);
      mem_wdata  = blank_word;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               is_read_in = 1'b0;
               state_in   = ST_FINISH;
               case (req_tuser)
                  CMD_PUT: begin
                     mem_we    = move.write_en;
                     mem_waddr = cursor_addr;
                     mem_wdata = {attr_ff, req_char};
                     if (move.scroll) begin
                        ptr_in   = '0;
                        state_in = ST_COPY;
                     end
                  end
                  CMD_CLEAR: begin
                     ptr_in   = '0;
                     state_in = ST_FILL;
                  end
                  CMD_READ: begin
                     mem_re     = read_ok;
                     mem_raddr  = read_addr_full[ADDR_W-1:0];
                     is_read_in = read_ok;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_COPY: begin
            mem_re    = copy_issue;
            mem_we    = pend_ff;
            mem_waddr = waddr_ff;
            mem_wdata = rd_data_ff;
            pend_in   = copy_issue;
            waddr_in  = ptr_ff;
            if (copy_issue) begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_ff[mem_raddr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         attr_ff      <= ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         is_read_ff   <= is_read_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      waddr_ff <= waddr_in;
      if (rsp_load) begin
         rsp_cell_ff <= is_read_ff ? rd_data_ff : 16'h0000;
         rsp_col_ff  <= 7'(cur_col);
         rsp_row_ff  <= 5'(cur_row);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_row_ff, rsp_col_ff, rsp_cell_ff};

   `TCC_ASSERT(a_copy_no_overlap, clock, reset,
      !((state_ff == ST_COPY) && mem_we && mem_re) || (mem_waddr != mem_raddr),
      "scroll copy read and write hit the same cell")
   `TCC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_accept, state_ff != ST_IDLE,
      "sequencer stayed idle after a request")
   `TCC_ASSERT_NEXT(a_finish_loads_result, clock, reset,
      rsp_load, rsp_tvalid && (state_ff == ST_IDLE),
      "result not presented after finish")

endmodule

### hw/rtl/tcc_cursor.sv
// Cursor position register and its update for put and clear transactions.
// Depends on tcc_pkg and the assertion macro header.
`timescale 1ns / 1ps

module tcc_cursor #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tcc_pkg::tcc_step_type       step,
   output tcc_pkg::tcc_move_type       move,
   output logic [$clog2(COLUMNS)-1:0]  cursor_col,
   output logic [$clog2(ROWS)-1:0]     cursor_row
);
   import tcc_pkg::*;
   `include "text_console_cursor_scroll_top_assert.svh"

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] line_ff, line_in;
   logic             is_nl, is_cr, last_col, last_row, wrap;

   always_comb begin
      is_nl    = (step.char_code == NEWLINE_CHAR);
      is_cr    = (step.char_code == RETURN_CHAR);
      last_col = (col_ff == COL_W'(COLUMNS - 1));
      last_row = (line_ff == ROW_W'(ROWS - 1));
      wrap     = step.put_en && (is_nl || (!is_cr && last_col));
      move.write_en = step.put_en && !is_nl && !is_cr;
      move.scroll   = wrap && last_row;
      col_in  = col_ff;
      line_in = line_ff;
      if (step.clear_en) begin
         col_in  = '0;
         line_in = '0;
      end else if (wrap) begin
         col_in = '0;
         if (!last_row) begin
            line_in = line_ff + ROW_W'(1);
         end
      end else if (move.write_en) begin
         col_in = col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

   assign cursor_col = col_ff;
   assign cursor_row = line_ff;

   `TCC_ASSERT(a_cursor_in_range, clock, reset,
      (col_ff <= COL_W'(COLUMNS - 1)) && (line_ff <= ROW_W'(ROWS - 1)),
      "cursor left the screen")

endmodule
